// File: rtl/evhf_pkg.sv
// Shared types and constants of the ego velocity and heading fusion block.
package evhf_pkg;

  localparam int unsigned Q_W        = 32;  // Q16.16 sample word
  localparam int unsigned LIM_W      = 31;  // spike and age limits
  localparam int unsigned GAIN_W     = 17;  // blend gain, Q1.16
  localparam int unsigned HEAD_W     = 25;  // wrapped heading
  localparam int unsigned SUM_W      = 49;  // heading sum before wrapping
  localparam int unsigned PROD_W     = 64;  // rate times step, Q32.32
  localparam int unsigned RND_W      = 48;  // product rounded to Q32.16
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [LIM_W-1:0]  GPS_AGE_RST     = 31'd3276800;
  localparam logic [LIM_W-1:0]  ACCEL_SPIKE_RST = 31'd196608;
  localparam logic [LIM_W-1:0]  YAW_SPIKE_RST   = 31'd1966080;
  localparam logic [LIM_W-1:0]  GPS_SPIKE_RST   = 31'd655360;
  localparam logic [GAIN_W-1:0] BLEND_GAIN_RST  = 17'd19661;
  localparam logic [LIM_W-1:0]  FALLBACK_RST    = 31'd655;
  localparam logic [GAIN_W-1:0] GAIN_ONE        = 17'd65536;

  // A full turn is 360 * 2^16 = 45 * 2^19, so the wrap works on the bits above
  // bit 18 modulo 45 and passes the low 19 bits through.
  localparam int unsigned WRAP_LO_W     = 19;
  localparam int unsigned WRAP_HI_W     = SUM_W - WRAP_LO_W;  // 30
  localparam int unsigned WRAP_DIGIT_W  = 3;
  localparam int unsigned WRAP_DIGITS   = WRAP_HI_W / WRAP_DIGIT_W;
  localparam int unsigned WRAP_REM_W    = 6;
  localparam logic [WRAP_REM_W-1:0] WRAP_MOD    = 6'd45;
  localparam logic [WRAP_REM_W-1:0] WRAP_SIGN_R = 6'd19;  // 2^30 mod 45
  localparam logic [WRAP_REM_W-1:0] WRAP_SIGN_C = 6'd26;  // 45 - 19
  localparam logic signed [SUM_W-1:0] HALF_TURN_S = 49'sd11796480;
  localparam logic [HEAD_W-1:0]       HALF_TURN   = 25'd11796480;
  localparam logic [HEAD_W:0]         FULL_TURN   = 26'd23592960;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GPS_AGE       = 3'd0,
    CFG_ACCEL_SPIKE   = 3'd1,
    CFG_YAW_SPIKE     = 3'd2,
    CFG_GPS_SPIKE     = 3'd3,
    CFG_BLEND_GAIN    = 3'd4,
    CFG_FALLBACK_STEP = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AX,
    MUL_AY,
    MUL_YR,
    MUL_BX,
    MUL_BY
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_VX,
    ACC_VY,
    ACC_H,
    ACC_BX,
    ACC_BY
  } acc_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_H,
    ST_ACC_H,
    ST_BLEND_X,
    ST_BLEND_Y,
    ST_BLEND_FIN,
    ST_WRAP_GO,
    ST_WRAP_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     check;
    mul_sel_e mul_sel;
    acc_sel_e acc_sel;
    logic     wrap_start;
    logic     finish;
  } evhf_cmd_t;

  typedef struct packed {
    logic use_gps;
    logic wrap_done;
  } evhf_status_t;

endpackage

// File: rtl/evhf_wrap.sv
// Iterative heading wrap unit: reduces the heading sum modulo a full turn.
module evhf_wrap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [evhf_pkg::SUM_W-1:0]   h_i,
  output logic                                done_o,
  output logic signed [evhf_pkg::HEAD_W-1:0]  heading_o
);
  import evhf_pkg::*;

  localparam int unsigned CNT_W = $clog2(WRAP_DIGITS + 1);

  logic                         busy_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [WRAP_HI_W-1:0]         hi_q;
  logic [WRAP_LO_W-1:0]         lo_q;
  logic                         neg_q;
  logic signed [SUM_W-1:0]      hsum_q;
  logic [WRAP_REM_W-1:0]        rem_q;
  logic [WRAP_REM_W-1:0]        rem_d;
  logic [8:0]                   val;
  logic [2:0]                   quo;
  logic [WRAP_REM_W-1:0]        rem_fix;
  logic [HEAD_W-1:0]            m;
  logic [HEAD_W:0]              m_low;
  logic                         above;
  logic                         below;

  // One octal digit per cycle: the running remainder stays below 45, so the
  // shifted value stays below 360 and one of eight multiples is taken off.
  always_comb begin
    val = {rem_q, hi_q[WRAP_HI_W-1 -: WRAP_DIGIT_W]};
    quo = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (val >= 9'(i * 45)) begin
        quo = 3'(i);
      end
    end
    rem_d = 6'(val - 9'(quo) * 9'(WRAP_MOD));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(WRAP_DIGITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q   <= h_i[SUM_W-1:WRAP_LO_W];
      lo_q   <= h_i[WRAP_LO_W-1:0];
      neg_q  <= h_i[SUM_W-1];
      hsum_q <= h_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      hi_q  <= hi_q << WRAP_DIGIT_W;
      rem_q <= rem_d;
    end
  end

  // The upper bits were taken as unsigned; a negative sum owes 2^30 mod 45.
  always_comb begin
    if (neg_q) begin
      rem_fix = (rem_q >= WRAP_SIGN_R) ? rem_q - WRAP_SIGN_R : rem_q + WRAP_SIGN_C;
    end else begin
      rem_fix = rem_q;
    end
    m     = {rem_fix, lo_q};
    m_low = {1'b0, m} - FULL_TURN;
    above = hsum_q > HALF_TURN_S;
    below = hsum_q < -HALF_TURN_S;
    if (above) begin
      heading_o = (m > HALF_TURN) ? m_low[HEAD_W-1:0] : m;
    end else if (below) begin
      heading_o = (m >= HALF_TURN) ? m_low[HEAD_W-1:0] : m;
    end else begin
      heading_o = hsum_q[HEAD_W-1:0];
    end
  end

  assign done_o = !busy_q;

endmodule

// File: rtl/evhf_dp.sv
// Datapath: configuration, filter state, spike checks, shared multiplier and accumulator.
module evhf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [evhf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [evhf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        now_time_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        gps_time_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        gps_speed_x_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        gps_speed_y_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        imu_accel_x_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        imu_accel_y_i,
  input  logic signed [evhf_pkg::Q_W-1:0]        imu_yaw_rate_i,
  input  evhf_pkg::evhf_cmd_t                    cmd_i,
  output evhf_pkg::evhf_status_t                 status_o,
  output logic signed [evhf_pkg::Q_W-1:0]        est_speed_x_o,
  output logic signed [evhf_pkg::Q_W-1:0]        est_speed_y_o,
  output logic signed [evhf_pkg::Q_W-1:0]        est_accel_x_o,
  output logic signed [evhf_pkg::Q_W-1:0]        est_accel_y_o,
  output logic signed [evhf_pkg::HEAD_W-1:0]     est_heading_o,
  output logic                                   gps_applied_o
);
  import evhf_pkg::*;

  // Configuration
  logic [LIM_W-1:0]  age_lim_q, accel_lim_q, yaw_lim_q, gps_lim_q, fstep_q;
  logic [GAIN_W-1:0] gain_q;
  logic [GAIN_W-1:0] gain_eff;

  // Sample beat
  logic signed [Q_W-1:0] now_q, gt_q, gx_q, gy_q, ax_in_q, ay_in_q, yr_in_q;

  // Filter state
  logic signed [Q_W-1:0]    speed_x_q, speed_y_q, last_time_q;
  logic signed [HEAD_W-1:0] heading_q;
  logic signed [Q_W-1:0]    kept_ax_q, kept_ay_q, kept_yr_q, kept_gx_q, kept_gy_q;

  // Working registers
  logic [Q_W-1:0]          dt_q, dt_d;
  logic signed [Q_W-1:0]   ax_f_q, ay_f_q, yr_f_q;
  logic                    use_gps_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [Q_W-1:0]   vx_q, vy_q;
  logic signed [SUM_W-1:0] h_q;
  logic signed [Q_W:0]     dx_q, dy_q;

  logic signed [Q_W:0]     age_diff, dt_raw;
  logic [Q_W:0]            age_mag;
  logic                    age_ok;

  logic signed [33:0]      mul_a, mul_b;
  logic signed [67:0]      mul_p;
  logic signed [RND_W-1:0] rnd;
  logic signed [Q_W-1:0]   blend_pred;
  logic signed [RND_W-1:0] blend_rnd;

  logic                    wrap_done;
  logic signed [HEAD_W-1:0] wrap_heading;

  function automatic logic spike(input logic signed [Q_W-1:0] nv,
                                 input logic signed [Q_W-1:0] kv,
                                 input logic [LIM_W-1:0]      lim);
    logic signed [Q_W:0] d;
    logic [Q_W:0]        mag;
    d   = {nv[Q_W-1], nv} - {kv[Q_W-1], kv};
    mag = d[Q_W] ? -d : d;
    return mag > {2'b00, lim};
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

  // Round half up from Q32.32 to Q32.16.
  function automatic logic signed [RND_W-1:0] round16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] s;
    s = x + 64'sd32768;
    return s[PROD_W-1:16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_lim_q   <= GPS_AGE_RST;
      accel_lim_q <= ACCEL_SPIKE_RST;
      yaw_lim_q   <= YAW_SPIKE_RST;
      gps_lim_q   <= GPS_SPIKE_RST;
      gain_q      <= BLEND_GAIN_RST;
      fstep_q     <= FALLBACK_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_GPS_AGE:       age_lim_q   <= cfg_data_i;
        CFG_ACCEL_SPIKE:   accel_lim_q <= cfg_data_i;
        CFG_YAW_SPIKE:     yaw_lim_q   <= cfg_data_i;
        CFG_GPS_SPIKE:     gps_lim_q   <= cfg_data_i;
        CFG_BLEND_GAIN:    gain_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_FALLBACK_STEP: fstep_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gain_eff = gain_q[GAIN_W-1] ? GAIN_ONE : gain_q;

  always_comb begin
    age_diff = {now_q[Q_W-1], now_q} - {gt_q[Q_W-1], gt_q};
    age_mag  = age_diff[Q_W] ? -age_diff : age_diff;
    age_ok   = age_mag <= {2'b00, age_lim_q};
    dt_raw   = {now_q[Q_W-1], now_q} - {last_time_q[Q_W-1], last_time_q};
    dt_d     = dt_raw[Q_W] ? {1'b0, fstep_q} : dt_raw[Q_W-1:0];
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AX: begin
        mul_a = {{2{ax_f_q[Q_W-1]}}, ax_f_q};
        mul_b = {2'b00, dt_q};
      end
      MUL_AY: begin
        mul_a = {{2{ay_f_q[Q_W-1]}}, ay_f_q};
        mul_b = {2'b00, dt_q};
      end
      MUL_YR: begin
        mul_a = {{2{yr_f_q[Q_W-1]}}, yr_f_q};
        mul_b = {2'b00, dt_q};
      end
      MUL_BX: begin
        mul_a = {dx_q[Q_W], dx_q};
        mul_b = {17'd0, gain_eff};
      end
      MUL_BY: begin
        mul_a = {dy_q[Q_W], dy_q};
        mul_b = {17'd0, gain_eff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The blend is written as pred + g * (gps - pred), one product per axis.
  always_comb begin
    rnd        = round16(prod_q);
    blend_pred = (cmd_i.acc_sel == ACC_BY) ? vy_q : vx_q;
    blend_rnd  = round16({{16{blend_pred[Q_W-1]}}, blend_pred, 16'h0000} + prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q   <= now_time_i;
      gt_q    <= gps_time_i;
      gx_q    <= gps_speed_x_i;
      gy_q    <= gps_speed_y_i;
      ax_in_q <= imu_accel_x_i;
      ay_in_q <= imu_accel_y_i;
      yr_in_q <= imu_yaw_rate_i;
    end
    if (cmd_i.check) begin
      dt_q      <= dt_d;
      ax_f_q    <= spike(ax_in_q, kept_ax_q, accel_lim_q) ? kept_ax_q : ax_in_q;
      ay_f_q    <= spike(ay_in_q, kept_ay_q, accel_lim_q) ? kept_ay_q : ay_in_q;
      yr_f_q    <= spike(yr_in_q, kept_yr_q, yaw_lim_q) ? kept_yr_q : yr_in_q;
      use_gps_q <= age_ok && !spike(gx_q, kept_gx_q, gps_lim_q)
                          && !spike(gy_q, kept_gy_q, gps_lim_q);
    end
    prod_q <= mul_p[PROD_W-1:0];
    case (cmd_i.acc_sel)
      ACC_VX: vx_q <= sat32({{17{speed_x_q[Q_W-1]}}, speed_x_q} + {rnd[RND_W-1], rnd});
      ACC_VY: vy_q <= sat32({{17{speed_y_q[Q_W-1]}}, speed_y_q} + {rnd[RND_W-1], rnd});
      ACC_H: begin
        h_q  <= {{24{heading_q[HEAD_W-1]}}, heading_q} + {rnd[RND_W-1], rnd};
        dx_q <= {gx_q[Q_W-1], gx_q} - {vx_q[Q_W-1], vx_q};
        dy_q <= {gy_q[Q_W-1], gy_q} - {vy_q[Q_W-1], vy_q};
      end
      ACC_BX: vx_q <= sat32({blend_rnd[RND_W-1], blend_rnd});
      ACC_BY: vy_q <= sat32({blend_rnd[RND_W-1], blend_rnd});
      default: ;
    endcase
    if (cmd_i.finish) begin
      est_speed_x_o <= vx_q;
      est_speed_y_o <= vy_q;
      est_accel_x_o <= ax_f_q;
      est_accel_y_o <= ay_f_q;
      est_heading_o <= wrap_heading;
      gps_applied_o <= use_gps_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_x_q   <= '0;
      speed_y_q   <= '0;
      heading_q   <= '0;
      last_time_q <= '0;
      kept_ax_q   <= '0;
      kept_ay_q   <= '0;
      kept_yr_q   <= '0;
      kept_gx_q   <= '0;
      kept_gy_q   <= '0;
    end else if (cmd_i.finish) begin
      speed_x_q   <= vx_q;
      speed_y_q   <= vy_q;
      heading_q   <= wrap_heading;
      last_time_q <= now_q;
      kept_ax_q   <= ax_f_q;
      kept_ay_q   <= ay_f_q;
      kept_yr_q   <= yr_f_q;
      if (use_gps_q) begin
        kept_gx_q <= gx_q;
        kept_gy_q <= gy_q;
      end
    end
  end

  evhf_wrap u_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.wrap_start),
    .h_i       (h_q),
    .done_o    (wrap_done),
    .heading_o (wrap_heading)
  );

  assign status_o.use_gps   = use_gps_q;
  assign status_o.wrap_done = wrap_done;

endmodule

// File: rtl/evhf_ctrl.sv
// Controller: sequences one sample through the datapath and owns both handshakes.
module evhf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  evhf_pkg::evhf_status_t  status_i,
  output evhf_pkg::evhf_cmd_t     cmd_o
);
  import evhf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.check      = 1'b0;
    cmd_o.mul_sel    = MUL_NONE;
    cmd_o.acc_sel    = ACC_NONE;
    cmd_o.wrap_start = 1'b0;
    cmd_o.finish     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd_o.mul_sel = MUL_AX;
        state_d       = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.mul_sel = MUL_AY;
        cmd_o.acc_sel = ACC_VX;
        state_d       = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd_o.mul_sel = MUL_YR;
        cmd_o.acc_sel = ACC_VY;
        state_d       = ST_ACC_H;
      end
      ST_ACC_H: begin
        cmd_o.acc_sel = ACC_H;
        state_d       = status_i.use_gps ? ST_BLEND_X : ST_WRAP_GO;
      end
      // The heading wrap runs alongside the velocity blend.
      ST_BLEND_X: begin
        cmd_o.mul_sel    = MUL_BX;
        cmd_o.wrap_start = 1'b1;
        state_d          = ST_BLEND_Y;
      end
      ST_BLEND_Y: begin
        cmd_o.mul_sel = MUL_BY;
        cmd_o.acc_sel = ACC_BX;
        state_d       = ST_BLEND_FIN;
      end
      ST_BLEND_FIN: begin
        cmd_o.acc_sel = ACC_BY;
        state_d       = ST_WRAP_WAIT;
      end
      ST_WRAP_GO: begin
        cmd_o.wrap_start = 1'b1;
        state_d          = ST_WRAP_WAIT;
      end
      ST_WRAP_WAIT: begin
        if (status_i.wrap_done && (!out_valid_q || out_ready_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ego_velocity_heading_fusion_top.sv
// Top level of the ego velocity and heading fusion filter.
//
// Complementary filter for ego velocity and heading in signed Q16.16. Each input beat is one
// sensor sample; each produces exactly one result beat. Samples are taken one at a time: a
// sample is accepted in the idle state and the next only once its result is registered, which
// waits while the output register holds an unaccepted result. The heading wrap unit reduces
// the heading sum modulo a full turn one octal digit per cycle; it starts once the shared
// multiplier has integrated acceleration and yaw rate and runs alongside the velocity blend
// toward GPS. A finished result waits in the output register while the next sample is accepted.
// The user must write configuration registers through the plain write port only while no
// sample is in flight; the block does not enforce this. Writes to unused indices are ignored.
module ego_velocity_heading_fusion_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [evhf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [evhf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [evhf_pkg::Q_W-1:0]      now_time_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      gps_time_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      gps_speed_x_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      gps_speed_y_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      imu_accel_x_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      imu_accel_y_i,
  input  logic signed [evhf_pkg::Q_W-1:0]      imu_yaw_rate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [evhf_pkg::Q_W-1:0]      est_speed_x_o,
  output logic signed [evhf_pkg::Q_W-1:0]      est_speed_y_o,
  output logic signed [evhf_pkg::Q_W-1:0]      est_accel_x_o,
  output logic signed [evhf_pkg::Q_W-1:0]      est_accel_y_o,
  output logic signed [evhf_pkg::HEAD_W-1:0]   est_heading_o,
  output logic                                 gps_applied_o
);
  import evhf_pkg::*;

  evhf_cmd_t    cmd;
  evhf_status_t status;

  evhf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  evhf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .now_time_i     (now_time_i),
    .gps_time_i     (gps_time_i),
    .gps_speed_x_i  (gps_speed_x_i),
    .gps_speed_y_i  (gps_speed_y_i),
    .imu_accel_x_i  (imu_accel_x_i),
    .imu_accel_y_i  (imu_accel_y_i),
    .imu_yaw_rate_i (imu_yaw_rate_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .est_speed_x_o  (est_speed_x_o),
    .est_speed_y_o  (est_speed_y_o),
    .est_accel_x_o  (est_accel_x_o),
    .est_accel_y_o  (est_accel_y_o),
    .est_heading_o  (est_heading_o),
    .gps_applied_o  (gps_applied_o)
  );

endmodule

// File: tb/sv/tb_ego_velocity_heading_fusion_top.sv
// Self-checking testbench for the ego velocity and heading fusion filter.
module tb_ego_velocity_heading_fusion_top;
  import evhf_pkg::*;

  localparam longint ONE_Q16         = 65536;
  localparam longint HALF_TURN_Q     = HALF_TURN;
  localparam longint FULL_TURN_Q     = FULL_TURN;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     QUIET_LIMIT     = 4000;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] LIM_MAX      = 31'h7FFFFFFF;

  typedef struct packed {
    logic signed [Q_W-1:0] now_time;
    logic signed [Q_W-1:0] gps_time;
    logic signed [Q_W-1:0] gps_speed_x;
    logic signed [Q_W-1:0] gps_speed_y;
    logic signed [Q_W-1:0] imu_accel_x;
    logic signed [Q_W-1:0] imu_accel_y;
    logic signed [Q_W-1:0] imu_yaw_rate;
  } sensor_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0]    speed_x;
    logic signed [Q_W-1:0]    speed_y;
    logic signed [Q_W-1:0]    accel_x;
    logic signed [Q_W-1:0]    accel_y;
    logic signed [HEAD_W-1:0] heading;
    logic                     gps_used;
  } fusion_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_idx_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [Q_W-1:0]        now_time_i;
  logic signed [Q_W-1:0]        gps_time_i;
  logic signed [Q_W-1:0]        gps_speed_x_i;
  logic signed [Q_W-1:0]        gps_speed_y_i;
  logic signed [Q_W-1:0]        imu_accel_x_i;
  logic signed [Q_W-1:0]        imu_accel_y_i;
  logic signed [Q_W-1:0]        imu_yaw_rate_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [Q_W-1:0]        est_speed_x_o;
  logic signed [Q_W-1:0]        est_speed_y_o;
  logic signed [Q_W-1:0]        est_accel_x_o;
  logic signed [Q_W-1:0]        est_accel_y_o;
  logic signed [HEAD_W-1:0]     est_heading_o;
  logic                         gps_applied_o;

  // Register copies and filter state of the predictor.
  longint reg_age_limit, reg_accel_limit, reg_yaw_limit, reg_gps_limit;
  longint reg_gain, reg_fallback;
  longint vel_x, vel_y, head, prev_time;
  longint held_ax, held_ay, held_yaw, held_gx, held_gy;

  fusion_result_t expected_fusion[$];
  int             fault_count;
  int             quiet_cycles;
  bit             send_no_gaps;
  bit             recv_no_gaps;
  bit             hold_request;

  ego_velocity_heading_fusion_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .now_time_i     (now_time_i),
    .gps_time_i     (gps_time_i),
    .gps_speed_x_i  (gps_speed_x_i),
    .gps_speed_y_i  (gps_speed_y_i),
    .imu_accel_x_i  (imu_accel_x_i),
    .imu_accel_y_i  (imu_accel_y_i),
    .imu_yaw_rate_i (imu_yaw_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .est_speed_x_o  (est_speed_x_o),
    .est_speed_y_o  (est_speed_y_o),
    .est_accel_x_o  (est_accel_x_o),
    .est_accel_y_o  (est_accel_y_o),
    .est_heading_o  (est_heading_o),
    .gps_applied_o  (gps_applied_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_filter_model();
    reg_age_limit   = GPS_AGE_RST;
    reg_accel_limit = ACCEL_SPIKE_RST;
    reg_yaw_limit   = YAW_SPIKE_RST;
    reg_gps_limit   = GPS_SPIKE_RST;
    reg_gain        = BLEND_GAIN_RST;
    reg_fallback    = FALLBACK_RST;
    vel_x = 0; vel_y = 0; head = 0; prev_time = 0;
    held_ax = 0; held_ay = 0; held_yaw = 0; held_gx = 0; held_gy = 0;
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_GPS_AGE:       reg_age_limit   = val;
      CFG_ACCEL_SPIKE:   reg_accel_limit = val;
      CFG_YAW_SPIKE:     reg_yaw_limit   = val;
      CFG_GPS_SPIKE:     reg_gps_limit   = val;
      CFG_BLEND_GAIN:    reg_gain        = val[GAIN_W-1:0];
      CFG_FALLBACK_STEP: reg_fallback    = val;
      default: ;
    endcase
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 rate times Q16.16 step, rounded half up back to Q16.16.
  function automatic longint rate_times_dt(longint rate, longint dt);
    return (rate * dt + 32768) >>> 16;
  endfunction

  function automatic bit jumps(longint fresh, longint kept, longint limit);
    longint d;
    d = fresh - kept;
    if (d < 0) d = -d;
    return d > limit;
  endfunction

  function automatic longint blend_toward(longint pred, longint obs, longint g);
    return clamp32(((ONE_Q16 - g) * pred + g * obs + 32768) >>> 16);
  endfunction

  function automatic fusion_result_t fuse_sample(sensor_beat_t b);
    longint now_t, gps_t, gx, gy, ax, ay, yr, age, dt, vx, vy, h, g, turns;
    bit gps_ok;
    fusion_result_t r;
    now_t = $signed(b.now_time);
    gps_t = $signed(b.gps_time);
    gx    = $signed(b.gps_speed_x);
    gy    = $signed(b.gps_speed_y);
    ax    = $signed(b.imu_accel_x);
    ay    = $signed(b.imu_accel_y);
    yr    = $signed(b.imu_yaw_rate);

    age = now_t - gps_t;
    if (age < 0) age = -age;
    gps_ok = (age <= reg_age_limit);
    dt = now_t - prev_time;
    if (dt < 0) dt = reg_fallback;
    prev_time = now_t;

    if (jumps(ax, held_ax, reg_accel_limit)) ax = held_ax;
    if (jumps(ay, held_ay, reg_accel_limit)) ay = held_ay;
    if (jumps(yr, held_yaw, reg_yaw_limit)) yr = held_yaw;
    if (jumps(gx, held_gx, reg_gps_limit) || jumps(gy, held_gy, reg_gps_limit)) gps_ok = 1'b0;
    held_ax  = ax;
    held_ay  = ay;
    held_yaw = yr;
    if (gps_ok) begin
      held_gx = gx;
      held_gy = gy;
    end

    vx = clamp32(vel_x + rate_times_dt(ax, dt));
    vy = clamp32(vel_y + rate_times_dt(ay, dt));
    h  = head + rate_times_dt(yr, dt);
    if (gps_ok) begin
      g  = (reg_gain > longint'(GAIN_ONE)) ? longint'(GAIN_ONE) : reg_gain;
      vx = blend_toward(vx, gx, g);
      vy = blend_toward(vy, gy, g);
    end

    if (h > HALF_TURN_Q) begin
      turns = (h - HALF_TURN_Q + FULL_TURN_Q - 1) / FULL_TURN_Q;
      h -= turns * FULL_TURN_Q;
    end else if (h < -HALF_TURN_Q) begin
      turns = (-HALF_TURN_Q - h + FULL_TURN_Q - 1) / FULL_TURN_Q;
      h += turns * FULL_TURN_Q;
    end
    vel_x = vx;
    vel_y = vy;
    head  = h;

    r.speed_x  = vx[Q_W-1:0];
    r.speed_y  = vy[Q_W-1:0];
    r.accel_x  = ax[Q_W-1:0];
    r.accel_y  = ay[Q_W-1:0];
    r.heading  = h[HEAD_W-1:0];
    r.gps_used = gps_ok;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic sensor_beat_t mk_beat(longint nt, longint gt, longint gx, longint gy,
                                           longint ax, longint ay, longint yr);
    sensor_beat_t b;
    b.now_time     = nt[Q_W-1:0];
    b.gps_time     = gt[Q_W-1:0];
    b.gps_speed_x  = gx[Q_W-1:0];
    b.gps_speed_y  = gy[Q_W-1:0];
    b.imu_accel_x  = ax[Q_W-1:0];
    b.imu_accel_y  = ay[Q_W-1:0];
    b.imu_yaw_rate = yr[Q_W-1:0];
    return b;
  endfunction

  // A value around base that stays within the limit about four times in five.
  function automatic longint near(longint base, longint limit);
    longint span, offset;
    span   = limit + limit / 4;
    offset = longint'($urandom_range(0, 32'(span)));
    if ($urandom_range(0, 1)) offset = -offset;
    return base + offset;
  endfunction

  function automatic logic [Q_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Follows the current filter state so that most samples get past the spike checks.
  function automatic sensor_beat_t plausible_beat();
    longint nt, advance;
    if ($urandom_range(0, 15) == 0) advance = -longint'($urandom_range(1, 10 * 65536));
    else advance = $urandom_range(0, 3 * 65536);
    nt = prev_time + advance;
    return mk_beat(nt, near(nt, reg_age_limit), near(held_gx, reg_gps_limit),
                   near(held_gy, reg_gps_limit), near(held_ax, reg_accel_limit),
                   near(held_ay, reg_accel_limit), near(held_yaw, reg_yaw_limit));
  endfunction

  task automatic send_beat(sensor_beat_t b);
    int gap;
    gap = send_no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    now_time_i     <= b.now_time;
    gps_time_i     <= b.gps_time;
    gps_speed_x_i  <= b.gps_speed_x;
    gps_speed_y_i  <= b.gps_speed_y;
    imu_accel_x_i  <= b.imu_accel_x;
    imu_accel_y_i  <= b.imu_accel_y;
    imu_yaw_rate_i <= b.imu_yaw_rate;
    do @(posedge clk_i); while (!in_ready_o);
    expected_fusion.push_back(fuse_sample(b));
  endtask

  // Lowers valid and waits until every result is back and the block has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_fusion.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_register(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] age, logic [CFG_DATA_W-1:0] accel,
                           logic [CFG_DATA_W-1:0] yaw, logic [CFG_DATA_W-1:0] gps,
                           logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] fallback);
    write_reg(CFG_GPS_AGE, age);
    write_reg(CFG_ACCEL_SPIKE, accel);
    write_reg(CFG_YAW_SPIKE, yaw);
    write_reg(CFG_GPS_SPIKE, gps);
    write_reg(CFG_BLEND_GAIN, gain);
    write_reg(CFG_FALLBACK_STEP, fallback);
  endtask

  task automatic run_stream(int count);
    sensor_beat_t b;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        send_no_gaps = ($urandom_range(0, 3) == 0);
        recv_no_gaps = ($urandom_range(0, 3) == 0);
      end
      b = plausible_beat();
      case ($urandom_range(0, 9))
        7: b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        8: begin
          case ($urandom_range(0, 6))
            0: b.now_time     = $urandom;
            1: b.gps_time     = $urandom;
            2: b.gps_speed_x  = $urandom;
            3: b.gps_speed_y  = $urandom;
            4: b.imu_accel_x  = $urandom;
            5: b.imu_accel_y  = $urandom;
            default: b.imu_yaw_rate = $urandom;
          endcase
        end
        9: b = {corner_value(), corner_value(), corner_value(), corner_value(),
                corner_value(), corner_value(), corner_value()};
        default: ;
      endcase
      send_beat(b);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_field_extremes();
    send_beat(mk_beat(0, 0, 0, 0, 0, 0, 0));
    // Acceleration and yaw jumps exactly on their limits pass.
    send_beat(mk_beat(ONE_Q16, ONE_Q16, 2 * ONE_Q16, -2 * ONE_Q16, 3 * ONE_Q16, -3 * ONE_Q16,
                      30 * ONE_Q16));
    // One step beyond the limit is a spike and the kept value is used.
    send_beat(mk_beat(2 * ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16, -2 * ONE_Q16, 6 * ONE_Q16 + 1,
                      -6 * ONE_Q16 - 1, 0));
    // Time jumps to the top of the range: a huge step that saturates velocity.
    send_beat(mk_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(mk_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(mk_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_special_cases();
    wait_idle();
    write_all(GPS_AGE_RST, LIM_MAX, LIM_MAX, LIM_MAX, 31'(BLEND_GAIN_RST), FALLBACK_RST);
    send_beat(mk_beat(0, 0, 0, 0, 0, 0, 0));
    // Heading wraps upwards, downwards and over several turns.
    send_beat(mk_beat(10 * ONE_Q16, 10 * ONE_Q16, 0, 0, 0, 0, 35 * ONE_Q16));
    send_beat(mk_beat(20 * ONE_Q16, 20 * ONE_Q16, 0, 0, 0, 0, -35 * ONE_Q16));
    send_beat(mk_beat(30 * ONE_Q16, 30 * ONE_Q16, 0, 0, 0, 0, 100 * ONE_Q16));
    // GPS just too old, then exactly at the age limit.
    send_beat(mk_beat(31 * ONE_Q16, 81 * ONE_Q16 + 1, ONE_Q16, ONE_Q16, 0, 0, 0));
    send_beat(mk_beat(32 * ONE_Q16, 82 * ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0));
    wait_idle();
    write_reg(CFG_GPS_SPIKE, GPS_SPIKE_RST);
    send_beat(mk_beat(33 * ONE_Q16, 33 * ONE_Q16, 12 * ONE_Q16, ONE_Q16, 0, 0, 0));
    send_beat(mk_beat(34 * ONE_Q16, 34 * ONE_Q16, 11 * ONE_Q16, ONE_Q16, 0, 0, 0));
    // Time runs backwards, so the fallback step applies.
    send_beat(mk_beat(20 * ONE_Q16, 20 * ONE_Q16, 11 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16,
                      ONE_Q16));
    wait_idle();
    // A gain above one must act as exactly one.
    write_reg(CFG_BLEND_GAIN, 31'h1FFFF);
    send_beat(mk_beat(21 * ONE_Q16, 21 * ONE_Q16, 12 * ONE_Q16, 2 * ONE_Q16, ONE_Q16, ONE_Q16,
                      ONE_Q16));
    wait_idle();
    write_reg(CFG_BLEND_GAIN, 31'(GAIN_ONE));
    send_beat(mk_beat(22 * ONE_Q16, 22 * ONE_Q16, 13 * ONE_Q16, 3 * ONE_Q16, 0, 0, 0));
    wait_idle();
    // Writes to indices beyond the register file leave everything unchanged.
    write_reg(CFG_SPARE_LO, LIM_MAX);
    write_reg(CFG_SPARE_HI, '0);
    send_beat(mk_beat(23 * ONE_Q16, 23 * ONE_Q16, 14 * ONE_Q16, 4 * ONE_Q16, ONE_Q16, 0, 0));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_all('0, '0, '0, '0, '0, '0);
    run_stream(150);
    wait_idle();
    write_all(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX);
    run_stream(150);
  endtask

  // The receiver stalls for a long stretch while samples keep coming.
  task automatic test_backpressure();
    wait_idle();
    write_all(GPS_AGE_RST, ACCEL_SPIKE_RST, YAW_SPIKE_RST, GPS_SPIKE_RST,
              31'(BLEND_GAIN_RST), FALLBACK_RST);
    hold_request = 1'b1;
    run_stream(40);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      wait_idle();
      write_all(31'($urandom_range(0, 120 * 65536)), 31'($urandom_range(0, 8 * 65536)),
                31'($urandom_range(0, 60 * 65536)), 31'($urandom_range(0, 20 * 65536)),
                31'($urandom_range(0, 70000)), 31'($urandom_range(0, 2 * 65536)));
      run_stream(360);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    fusion_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fusion.size() == 0) begin
        $error("result beat arrived with nothing expected");
        fault_count++;
      end else begin
        want = expected_fusion.pop_front();
        check_field("est_speed_x", want.speed_x, est_speed_x_o);
        check_field("est_speed_y", want.speed_y, est_speed_y_o);
        check_field("est_accel_x", want.accel_x, est_accel_x_o);
        check_field("est_accel_y", want.accel_y, est_accel_y_o);
        check_field("est_heading", want.heading, est_heading_o);
        check_field("gps_applied", want.gps_used, gps_applied_o);
      end
    end
  end

  // Receiver: a random pause before each beat, or one long hold-off on request.
  initial begin : result_sink
    int pause;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pause = recv_no_gaps ? 0 : $urandom_range(0, 12);
      if (hold_request) begin
        pause        = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (pause > 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ego_velocity_heading_fusion_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fault_count    = 0;
    quiet_cycles   = 0;
    send_no_gaps   = 1'b0;
    recv_no_gaps   = 1'b0;
    hold_request   = 1'b0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    now_time_i     <= '0;
    gps_time_i     <= '0;
    gps_speed_x_i  <= '0;
    gps_speed_y_i  <= '0;
    imu_accel_x_i  <= '0;
    imu_accel_y_i  <= '0;
    imu_yaw_rate_i <= '0;
    reset_filter_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_special_cases();
    test_register_extremes();
    test_backpressure();
    test_random_settings();

    in_valid_i <= 1'b0;
    while (expected_fusion.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fault_count == 0 && expected_fusion.size() == 0) begin
      $display("tb_ego_velocity_heading_fusion_top: done, clean");
    end else begin
      $display("tb_ego_velocity_heading_fusion_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/evhf_pkg.sv
rtl/evhf_wrap.sv
rtl/evhf_dp.sv
rtl/evhf_ctrl.sv
rtl/ego_velocity_heading_fusion_top.sv
tb/sv/tb_ego_velocity_heading_fusion_top.sv
